// ----- design/lpmc_pkg.sv -----
// ----------------------------------------------------------------------------
// lpmc_pkg
// Shared types, constants and link templates of the lattice pattern mode
// controller.
// ----------------------------------------------------------------------------
package lpmc_pkg;

	// field widths
	localparam int ID_W     = 7;
	localparam int COUNT_W  = 16;
	localparam int REG_W    = 16;
	localparam int SCORE_W  = 4;
	localparam int RANK_W   = 4;
	localparam int LINKS    = 8;
	localparam int CFG_IDX_W = 2;

	// default agent count
	localparam int AGENTS_DEFAULT = 128;

	// register reset values
	localparam logic [REG_W-1:0] LINK_THRESHOLD_RST = 16'd50;
	localparam logic [REG_W-1:0] IMPROVE_WAIT_RST   = 16'd200;
	localparam logic [REG_W-1:0] CIRCLE_TIMEOUT_RST = 16'd1000;
	localparam logic [REG_W-1:0] WAIT_SCALE_RST     = 16'd200;

	localparam logic [COUNT_W-1:0] WAIT_MAX = 16'hFFFF;
	localparam logic [SCORE_W-1:0] SCORE_FULL = 4'd8;
	localparam logic [RANK_W-1:0]  RANK_MAX = 4'd8;
	localparam logic [RANK_W-1:0]  RANK_SPAN = 4'd9;

	// templates, bit j is direction j
	localparam int NUM_TEMPLATES = 9;
	localparam logic [LINKS-1:0] TMPL_BITS [NUM_TEMPLATES] = '{
		8'h06, 8'hC0, 8'h38, 8'hC7, 8'h3E, 8'hF8, 8'h7D, 8'h47, 8'hC5
	};
	localparam logic [RANK_W-1:0] TMPL_RANK [NUM_TEMPLATES] = '{
		4'd8, 4'd0, 4'd3, 4'd5, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2
	};

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINK_THRESHOLD = 2'd0,
		REG_IMPROVE_WAIT   = 2'd1,
		REG_CIRCLE_TIMEOUT = 2'd2,
		REG_WAIT_SCALE     = 2'd3
	} reg_idx_t;

	// motion kinds
	typedef enum logic [1:0] {
		MOTION_LATTICE = 2'd0,
		MOTION_ATTRACT = 2'd1,
		MOTION_CIRCLE  = 2'd2
	} motion_t;

	// template match summary
	typedef struct packed {
		logic [SCORE_W-1:0] best;
		logic [RANK_W-1:0]  rank;
		logic               hit;
		logic               opposite;
	} score_t;

	// per-agent state entry
	typedef struct packed {
		logic               circling;
		logic [COUNT_W-1:0] wait_cnt;
		logic [SCORE_W-1:0] score;
		logic [RANK_W-1:0]  rank;
	} entry_t;

endpackage

// ----- design/lpmc_step_if.sv -----
// ----------------------------------------------------------------------------
// lpmc_step_if
// Input channel: one agent's ids and eight neighbor-link counts per item.
// ----------------------------------------------------------------------------
interface lpmc_step_if;
	logic                             valid;
	logic                             ready;
	logic [lpmc_pkg::ID_W-1:0]        agent_id;
	logic [lpmc_pkg::ID_W-1:0]        neighbor_id;
	logic [lpmc_pkg::COUNT_W-1:0]     link_count_0;
	logic [lpmc_pkg::COUNT_W-1:0]     link_count_1;
	logic [lpmc_pkg::COUNT_W-1:0]     link_count_2;
	logic [lpmc_pkg::COUNT_W-1:0]     link_count_3;
	logic [lpmc_pkg::COUNT_W-1:0]     link_count_4;
	logic [lpmc_pkg::COUNT_W-1:0]     link_count_5;
	logic [lpmc_pkg::COUNT_W-1:0]     link_count_6;
	logic [lpmc_pkg::COUNT_W-1:0]     link_count_7;

	modport source (
		output valid, agent_id, neighbor_id,
		output link_count_0, link_count_1, link_count_2, link_count_3,
		output link_count_4, link_count_5, link_count_6, link_count_7,
		input  ready
	);

	modport sink (
		input  valid, agent_id, neighbor_id,
		input  link_count_0, link_count_1, link_count_2, link_count_3,
		input  link_count_4, link_count_5, link_count_6, link_count_7,
		output ready
	);
endinterface

// ----- design/lpmc_result_if.sv -----
// ----------------------------------------------------------------------------
// lpmc_result_if
// Output channel: motion kind and updated agent state per item.
// ----------------------------------------------------------------------------
interface lpmc_result_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       motion_kind;
	logic                             content;
	logic [lpmc_pkg::SCORE_W-1:0]     match_score;
	logic [lpmc_pkg::RANK_W-1:0]      pattern_rank;
	logic                             now_circling;
	logic [lpmc_pkg::COUNT_W-1:0]     wait_count;

	modport source (
		output valid, motion_kind, content, match_score, pattern_rank,
		output now_circling, wait_count,
		input  ready
	);

	modport sink (
		input  valid, motion_kind, content, match_score, pattern_rank,
		input  now_circling, wait_count,
		output ready
	);
endinterface

// ----- design/lattice_pattern_mode_controller_top.sv -----
// ----------------------------------------------------------------------------
// lattice_pattern_mode_controller_top
// Per-agent lattice pattern matcher and motion mode controller.
//
// Usage:
//   step channel: one item per agent control step (agent id, nearest
//   neighbor id, eight link counts). result channel: one item per step
//   with the motion kind, content flag, best score and the agent's updated
//   rank, circling flag and wait counter.
//   Config: cfg_we/cfg_index/cfg_data write one 16-bit register per cycle;
//   users must write only while the block is idle; it is not enforced.
//   Timing: an item is a read-modify-write of the agent state RAM: the
//   accept cycle issues the read at agent and neighbor (and thresholds
//   and scores the links), then the compute state computes the mode and
//   writes back once the output register is free. The result is valid the
//   cycle after that write; a new item is taken only after the write-back.
//   Stall: the result sits in an output register; a new item is still
//   taken, and its write-back waits until the output register is free.
//   Reset: registers return to their defaults, then a clearing pass zeroes
//   all AGENTS entries of the state RAM; step.ready is low during the pass.
// ----------------------------------------------------------------------------
module lattice_pattern_mode_controller_top #(
	parameter int AGENTS = lpmc_pkg::AGENTS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lpmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lpmc_pkg::REG_W-1:0]     cfg_data,
	lpmc_step_if.sink                      step,
	lpmc_result_if.source                  result
);

	localparam int IDX_W   = $clog2(AGENTS);
	localparam int ID_SPAN = 2 ** lpmc_pkg::ID_W;
	localparam int ENTRY_W = $bits(lpmc_pkg::entry_t);
	localparam int LIMIT_W = lpmc_pkg::REG_W + lpmc_pkg::RANK_W;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC
	} state_t;

	state_t st_q;
	logic [IDX_W-1:0] clr_cnt_q;

	logic [lpmc_pkg::REG_W-1:0] link_threshold_q;
	logic [lpmc_pkg::REG_W-1:0] improve_wait_q;
	logic [lpmc_pkg::REG_W-1:0] circle_timeout_q;
	logic [lpmc_pkg::REG_W-1:0] wait_scale_q;

	logic [IDX_W-1:0] mod_tbl [ID_SPAN];
	logic [IDX_W-1:0] id_idx;
	logic [IDX_W-1:0] nb_idx;
	logic [IDX_W-1:0] id_s1;
	logic [IDX_W-1:0] nb_s1;

	logic [lpmc_pkg::LINKS-1:0] links;
	lpmc_pkg::score_t score;
	lpmc_pkg::score_t score_s1;

	logic step_acc;
	logic calc_go;
	logic res_valid_q;

	logic ram_we;
	logic [IDX_W-1:0] ram_waddr;
	lpmc_pkg::entry_t ram_wdata;
	lpmc_pkg::entry_t ent;
	lpmc_pkg::entry_t nb_ent;
	logic [ENTRY_W-1:0] rdata_a;
	logic [ENTRY_W-1:0] rdata_b;

	// next-state results
	lpmc_pkg::entry_t new_ent;
	lpmc_pkg::motion_t motion;
	logic content;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_threshold_q <= lpmc_pkg::LINK_THRESHOLD_RST;
			improve_wait_q   <= lpmc_pkg::IMPROVE_WAIT_RST;
			circle_timeout_q <= lpmc_pkg::CIRCLE_TIMEOUT_RST;
			wait_scale_q     <= lpmc_pkg::WAIT_SCALE_RST;
		end else if (cfg_we) begin
			unique case (lpmc_pkg::reg_idx_t'(cfg_index))
				lpmc_pkg::REG_LINK_THRESHOLD: link_threshold_q <= cfg_data;
				lpmc_pkg::REG_IMPROVE_WAIT:   improve_wait_q   <= cfg_data;
				lpmc_pkg::REG_CIRCLE_TIMEOUT: circle_timeout_q <= cfg_data;
				lpmc_pkg::REG_WAIT_SCALE:     wait_scale_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// agent index wrap table
	for (genvar g = 0; g < ID_SPAN; g++) begin : g_mod
		localparam int REM = g % AGENTS;
		assign mod_tbl[g] = IDX_W'(REM);
	end

	assign id_idx = mod_tbl[step.agent_id];
	assign nb_idx = mod_tbl[step.neighbor_id];

	// link thresholding
	assign links = {
		step.link_count_7 > link_threshold_q,
		step.link_count_6 > link_threshold_q,
		step.link_count_5 > link_threshold_q,
		step.link_count_4 > link_threshold_q,
		step.link_count_3 > link_threshold_q,
		step.link_count_2 > link_threshold_q,
		step.link_count_1 > link_threshold_q,
		step.link_count_0 > link_threshold_q
	};

	lpmc_score u_score (
		.links (links),
		.score (score)
	);

	// handshake
	assign step.ready = (st_q == ST_IDLE);
	assign step_acc   = step.valid && step.ready;
	assign calc_go    = (st_q == ST_CALC) && (!res_valid_q || result.ready);

	// captured item
	always_ff @(posedge clk) begin
		if (step_acc) begin
			id_s1    <= id_idx;
			nb_s1    <= nb_idx;
			score_s1 <= score;
		end
	end

	// agent state RAM
	assign ram_we    = (st_q == ST_CLEAR) || calc_go;
	assign ram_waddr = (st_q == ST_CLEAR) ? clr_cnt_q : id_s1;
	assign ram_wdata = (st_q == ST_CLEAR) ? '0 : new_ent;

	lpmc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (AGENTS)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (step_acc),
		.raddr_a (id_idx),
		.raddr_b (nb_idx),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	assign ent    = lpmc_pkg::entry_t'(rdata_a);
	assign nb_ent = lpmc_pkg::entry_t'(rdata_b);

	// mode update
	always_comb begin
		logic [lpmc_pkg::SCORE_W-1:0] best;
		logic [lpmc_pkg::RANK_W-1:0]  rank;
		logic [lpmc_pkg::RANK_W-1:0]  rank_cl;
		logic [lpmc_pkg::COUNT_W-1:0] w;
		logic [lpmc_pkg::COUNT_W-1:0] w_inc;
		logic [LIMIT_W-1:0]           limit;
		logic                         improved;
		logic                         nb_flag;
		logic                         flag;
		best    = score_s1.best;
		rank    = score_s1.hit ? score_s1.rank : ent.rank;
		content = (score_s1.best == lpmc_pkg::SCORE_FULL);
		// opposite pair overrides a partial match
		if (!content && score_s1.opposite) begin
			content = 1'b1;
			rank    = '0;
			best    = lpmc_pkg::SCORE_FULL;
		end
		rank_cl  = (rank > lpmc_pkg::RANK_MAX) ? lpmc_pkg::RANK_MAX : rank;
		limit    = LIMIT_W'(wait_scale_q) * LIMIT_W'(lpmc_pkg::RANK_SPAN - rank_cl);
		improved = (best > ent.score);
		w        = ent.wait_cnt;
		if (improved && (w > improve_wait_q)) begin
			w = '0;
		end
		w_inc = (w == lpmc_pkg::WAIT_MAX) ? w : w + 1'b1;
		// own flag reads as cleared when the neighbor is the agent itself
		nb_flag = (nb_s1 != id_s1) && nb_ent.circling;
		flag    = ent.circling;
		if (content) begin
			flag   = 1'b0;
			motion = nb_flag ? lpmc_pkg::MOTION_ATTRACT : lpmc_pkg::MOTION_LATTICE;
		end else if (ent.circling) begin
			// improvement term sees the cleared counter
			motion = lpmc_pkg::MOTION_CIRCLE;
			if ((improved && (w > improve_wait_q)) || (w > circle_timeout_q)) begin
				flag = 1'b0;
				w    = '0;
			end else begin
				w = w_inc;
			end
		end else begin
			motion = nb_flag ? lpmc_pkg::MOTION_ATTRACT : lpmc_pkg::MOTION_LATTICE;
			if (LIMIT_W'(w) > limit) begin
				flag = 1'b1;
				w    = '0;
			end else begin
				w = w_inc;
			end
		end
		new_ent.circling = flag;
		new_ent.wait_cnt = w;
		new_ent.score    = best;
		new_ent.rank     = rank;
	end

	// control state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			clr_cnt_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == IDX_W'(AGENTS - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (step_acc) begin
						st_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (calc_go) begin
						res_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (calc_go) begin
			result.motion_kind  <= motion;
			result.content      <= content;
			result.match_score  <= new_ent.score;
			result.pattern_rank <= new_ent.rank;
			result.now_circling <= new_ent.circling;
			result.wait_count   <= new_ent.wait_cnt;
		end
	end

	assign result.valid = res_valid_q;

	// checks
	a_no_rd_on_wb: assert property (@(posedge clk) disable iff (!arst_n)
		calc_go |-> !step_acc)
		else $error("state read issued during write-back");

	a_rise_after_calc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(st_q == ST_CALC))
		else $error("result appeared without a compute cycle");

	a_content_no_circle: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.content) |->
			(!result.now_circling && (result.motion_kind != lpmc_pkg::MOTION_CIRCLE)))
		else $error("content agent left circling");

	a_circle_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.now_circling && !$past(result.valid)) |->
			(result.motion_kind == lpmc_pkg::MOTION_CIRCLE || result.wait_count == '0))
		else $error("circling started without clearing the counter");

endmodule

// ----- design/lpmc_ram.sv -----
// ----------------------------------------------------------------------------
// lpmc_ram
// Generic synchronous RAM: one write port, two read ports with registered
// read data updated on read enable.
// ----------------------------------------------------------------------------
module lpmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read ports
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ----- design/lpmc_score.sv -----
// ----------------------------------------------------------------------------
// lpmc_score
// Scores an 8-bit link vector against the fixed link templates and flags
// opposite link pairs.
// ----------------------------------------------------------------------------
module lpmc_score (
	input  logic [lpmc_pkg::LINKS-1:0] links,
	output lpmc_pkg::score_t           score
);

	// first strictly better template wins
	always_comb begin
		logic [lpmc_pkg::SCORE_W-1:0] best;
		logic [lpmc_pkg::RANK_W-1:0]  rank;
		logic [lpmc_pkg::SCORE_W-1:0] s;
		best = '0;
		rank = '0;
		for (int t = 0; t < lpmc_pkg::NUM_TEMPLATES; t++) begin
			s = lpmc_pkg::SCORE_FULL
				- lpmc_pkg::SCORE_W'($countones(links ^ lpmc_pkg::TMPL_BITS[t]));
			if (s > best) begin
				best = s;
				rank = lpmc_pkg::TMPL_RANK[t];
			end
		end
		score.best     = best;
		score.rank     = rank;
		score.hit      = (best != '0);
		// opposite directions both present
		score.opposite = |(links[3:0] & links[7:4]);
	end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lattice pattern mode controller. A directed
// table covers threshold edges, exact and opposite-link matches, circling
// entry and exit, improvement and self neighbors. Random phases with bursty
// steps and a stalling result sink follow under several register settings.
// Every result is checked per field against a behavioral model or typed row.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int AGENTS       = lpmc_pkg::AGENTS_DEFAULT;
	localparam int IDLE_LIMIT   = 3000;
	localparam int PHASE_STEPS  = 270;
	localparam int NUM_PHASES   = 7;

	typedef logic [lpmc_pkg::LINKS-1:0][lpmc_pkg::COUNT_W-1:0] link_counts_t;

	// one controller decision, as seen on the result channel
	typedef struct packed {
		lpmc_pkg::motion_t            motion;
		logic                         content;
		logic [lpmc_pkg::SCORE_W-1:0] score;
		logic [lpmc_pkg::RANK_W-1:0]  rank;
		logic                         circling;
		logic [lpmc_pkg::COUNT_W-1:0] wait_cnt;
	} decision_t;

	typedef enum logic {
		ROW_STEP,
		ROW_SETTINGS
	} row_kind_t;

	// one line of the directed table
	typedef struct packed {
		row_kind_t                          kind;
		logic [lpmc_pkg::ID_W-1:0]          agent;
		logic [lpmc_pkg::ID_W-1:0]          nb;
		logic [lpmc_pkg::LINKS-1:0]         mask;
		logic [lpmc_pkg::COUNT_W-1:0]       hi;
		logic [lpmc_pkg::COUNT_W-1:0]       lo;
		logic                               typed;
		decision_t                          want;
		logic [3:0][lpmc_pkg::REG_W-1:0]    regs;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [lpmc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [lpmc_pkg::REG_W-1:0] cfg_data;

	lpmc_step_if   step_bus ();
	lpmc_result_if result_bus ();

	lattice_pattern_mode_controller_top #(
		.AGENTS (AGENTS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step_bus),
		.result    (result_bus)
	);

	always #5 clk = ~clk;

	// model copy of registers and per-agent memory
	logic [lpmc_pkg::REG_W-1:0] link_threshold_q;
	logic [lpmc_pkg::REG_W-1:0] improve_wait_q;
	logic [lpmc_pkg::REG_W-1:0] circle_timeout_q;
	logic [lpmc_pkg::REG_W-1:0] wait_scale_q;
	lpmc_pkg::entry_t           agent_mem [AGENTS];

	decision_t                  pending_decisions [$];
	directed_row_t              directed_rows [$];
	logic [lpmc_pkg::LINKS-1:0] home_mask [AGENTS];

	int errors;
	int steps_sent;
	int results_checked;
	int settings_applied;
	int content_seen;
	int circling_seen;
	int attract_seen;
	int saturated_seen;

	// sender burst state
	int burst_left;

	// receiver stall state
	int stall_mode;
	int stall_window;
	int stall_period;
	int stall_phase;

	// ------------------------------------------------------------------------
	// behavioral model of one control step
	// ------------------------------------------------------------------------
	function automatic decision_t decide_mode(input logic [lpmc_pkg::ID_W-1:0] aid,
			input logic [lpmc_pkg::ID_W-1:0] nid, input link_counts_t cnt);
		decision_t                    d;
		logic [lpmc_pkg::LINKS-1:0]   links;
		logic [lpmc_pkg::LINKS-1:0]   diff;
		logic [lpmc_pkg::SCORE_W-1:0] best;
		logic [lpmc_pkg::SCORE_W-1:0] s;
		logic [lpmc_pkg::RANK_W-1:0]  rank;
		logic [lpmc_pkg::RANK_W-1:0]  span;
		logic [lpmc_pkg::COUNT_W-1:0] w;
		logic content;
		logic improved;
		int unsigned limit;
		int id;
		int nb;
		int miss;

		id = aid % AGENTS;
		nb = nid % AGENTS;
		rank = agent_mem[id].rank;
		best = '0;
		for (int j = 0; j < lpmc_pkg::LINKS; j++)
			links[j] = cnt[j] > link_threshold_q;

		// first strictly better template wins
		for (int t = 0; t < lpmc_pkg::NUM_TEMPLATES; t++) begin
			diff = links ^ lpmc_pkg::TMPL_BITS[t];
			miss = 0;
			for (int j = 0; j < lpmc_pkg::LINKS; j++)
				miss += diff[j];
			s = lpmc_pkg::SCORE_FULL - miss;
			if (s > best) begin
				best = s;
				rank = lpmc_pkg::TMPL_RANK[t];
			end
		end

		// opposite links also make the agent content
		content = (best == lpmc_pkg::SCORE_FULL);
		if (!content && ((links[3:0] & links[7:4]) != 4'd0)) begin
			content = 1'b1;
			rank = '0;
			best = lpmc_pkg::SCORE_FULL;
		end
		agent_mem[id].rank = rank;

		// improvement past the improve wait clears the counter before the mode logic
		w = agent_mem[id].wait_cnt;
		improved = best > agent_mem[id].score;
		if (improved && w > improve_wait_q)
			w = '0;

		if (content) begin
			agent_mem[id].circling = 1'b0;
			d.motion = agent_mem[nb].circling ? lpmc_pkg::MOTION_ATTRACT
				: lpmc_pkg::MOTION_LATTICE;
		end else if (agent_mem[id].circling) begin
			d.motion = lpmc_pkg::MOTION_CIRCLE;
			if ((improved && w > improve_wait_q) || w > circle_timeout_q) begin
				agent_mem[id].circling = 1'b0;
				w = '0;
			end else if (w != lpmc_pkg::WAIT_MAX) begin
				w = w + 1'b1;
			end
		end else begin
			d.motion = agent_mem[nb].circling ? lpmc_pkg::MOTION_ATTRACT
				: lpmc_pkg::MOTION_LATTICE;
			span = lpmc_pkg::RANK_SPAN
				- ((rank > lpmc_pkg::RANK_MAX) ? lpmc_pkg::RANK_MAX : rank);
			limit = wait_scale_q * span;
			if (w > limit) begin
				agent_mem[id].circling = 1'b1;
				w = '0;
			end else if (w != lpmc_pkg::WAIT_MAX) begin
				w = w + 1'b1;
			end
		end
		agent_mem[id].wait_cnt = w;
		agent_mem[id].score = best;

		d.content = content;
		d.score = best;
		d.rank = rank;
		d.circling = agent_mem[id].circling;
		d.wait_cnt = w;
		return d;
	endfunction

	// counts that land on the requested link mask, often at the threshold edge
	function automatic link_counts_t counts_for(input logic [lpmc_pkg::LINKS-1:0] mask);
		link_counts_t c;
		int unsigned lo_b;
		int unsigned hi_b;

		for (int j = 0; j < lpmc_pkg::LINKS; j++) begin
			if (mask[j] && link_threshold_q != lpmc_pkg::WAIT_MAX) begin
				lo_b = link_threshold_q + 1;
				hi_b = 65535;
			end else begin
				lo_b = 0;
				hi_b = link_threshold_q;
			end
			if ($urandom_range(0, 7) == 0)
				c[j] = mask[j] ? lo_b : hi_b;
			else
				c[j] = $urandom_range(hi_b, lo_b);
		end
		return c;
	endfunction

	// ------------------------------------------------------------------------
	// step sender
	// ------------------------------------------------------------------------
	task automatic send_step(input logic [lpmc_pkg::ID_W-1:0] aid,
			input logic [lpmc_pkg::ID_W-1:0] nid,
			input link_counts_t cnt, input logic typed, input decision_t want);
		decision_t d;
		int gap;

		step_bus.valid        <= 1'b1;
		step_bus.agent_id     <= aid;
		step_bus.neighbor_id  <= nid;
		step_bus.link_count_0 <= cnt[0];
		step_bus.link_count_1 <= cnt[1];
		step_bus.link_count_2 <= cnt[2];
		step_bus.link_count_3 <= cnt[3];
		step_bus.link_count_4 <= cnt[4];
		step_bus.link_count_5 <= cnt[5];
		step_bus.link_count_6 <= cnt[6];
		step_bus.link_count_7 <= cnt[7];
		do @(posedge clk); while (!step_bus.ready);

		d = decide_mode(aid, nid, cnt);
		pending_decisions.insert(pending_decisions.size(), typed ? want : d);
		steps_sent++;
		content_seen   += d.content;
		circling_seen  += (d.motion == lpmc_pkg::MOTION_CIRCLE);
		attract_seen   += (d.motion == lpmc_pkg::MOTION_ATTRACT);
		saturated_seen += (d.wait_cnt == lpmc_pkg::WAIT_MAX);

		// bursts of random length with random gaps
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				step_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// wait until every outstanding item has come back
	task automatic drain_pending();
		step_bus.valid <= 1'b0;
		while (pending_decisions.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input lpmc_pkg::reg_idx_t idx,
			input logic [lpmc_pkg::REG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			lpmc_pkg::REG_LINK_THRESHOLD: link_threshold_q = value;
			lpmc_pkg::REG_IMPROVE_WAIT:   improve_wait_q   = value;
			lpmc_pkg::REG_CIRCLE_TIMEOUT: circle_timeout_q = value;
			lpmc_pkg::REG_WAIT_SCALE:     wait_scale_q     = value;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [lpmc_pkg::REG_W-1:0] thr,
			input logic [lpmc_pkg::REG_W-1:0] imp,
			input logic [lpmc_pkg::REG_W-1:0] tmo, input logic [lpmc_pkg::REG_W-1:0] scl);
		drain_pending();
		write_reg(lpmc_pkg::REG_LINK_THRESHOLD, thr);
		write_reg(lpmc_pkg::REG_IMPROVE_WAIT, imp);
		write_reg(lpmc_pkg::REG_CIRCLE_TIMEOUT, tmo);
		write_reg(lpmc_pkg::REG_WAIT_SCALE, scl);
		cfg_we <= 1'b0;
		settings_applied++;
	endtask

	// ------------------------------------------------------------------------
	// directed table builders
	// ------------------------------------------------------------------------
	task automatic add_step(input logic [lpmc_pkg::ID_W-1:0] aid,
			input logic [lpmc_pkg::ID_W-1:0] nid,
			input logic [lpmc_pkg::LINKS-1:0] mask, input logic [lpmc_pkg::COUNT_W-1:0] hi,
			input logic [lpmc_pkg::COUNT_W-1:0] lo, input logic typed, input decision_t want);
		directed_row_t r;
		r = '0;
		r.kind = ROW_STEP;
		r.agent = aid;
		r.nb = nid;
		r.mask = mask;
		r.hi = hi;
		r.lo = lo;
		r.typed = typed;
		r.want = want;
		directed_rows.insert(directed_rows.size(), r);
	endtask

	task automatic add_settings(input logic [lpmc_pkg::REG_W-1:0] thr,
			input logic [lpmc_pkg::REG_W-1:0] imp,
			input logic [lpmc_pkg::REG_W-1:0] tmo, input logic [lpmc_pkg::REG_W-1:0] scl);
		directed_row_t r;
		r = '0;
		r.kind = ROW_SETTINGS;
		r.regs = {scl, tmo, imp, thr};
		directed_rows.insert(directed_rows.size(), r);
	endtask

	task automatic build_directed();
		// register defaults: empty, exact, threshold edge and opposite links
		add_step(7'd0, 7'd1, 8'h00, 16'd0, 16'd0, 1'b1,
			'{lpmc_pkg::MOTION_LATTICE, 1'b0, 4'd6, 4'd8, 1'b0, 16'd1});
		add_step(7'd1, 7'd0, 8'hFF, 16'hFFFF, 16'd0, 1'b1,
			'{lpmc_pkg::MOTION_LATTICE, 1'b1, 4'd8, 4'd0, 1'b0, 16'd0});
		add_step(7'd2, 7'd2, 8'h00, 16'd0, 16'd50, 1'b1,
			'{lpmc_pkg::MOTION_LATTICE, 1'b0, 4'd6, 4'd8, 1'b0, 16'd1});
		add_step(7'd3, 7'd3, 8'hFF, 16'd51, 16'd0, 1'b1,
			'{lpmc_pkg::MOTION_LATTICE, 1'b1, 4'd8, 4'd0, 1'b0, 16'd0});
		add_step(7'd127, 7'd127, 8'h06, 16'hFFFF, 16'd0, 1'b1,
			'{lpmc_pkg::MOTION_LATTICE, 1'b1, 4'd8, 4'd8, 1'b0, 16'd0});

		// short timers so agents enter and leave circling quickly
		add_settings(16'd1000, 16'd2, 16'd4, 16'd1);
		repeat (3) add_step(7'd5, 7'd6, 8'h00, 16'hFFFF, 16'd0, 1'b0, '0);
		// neighbor circling gives attraction
		add_step(7'd6, 7'd5, 8'h00, 16'hFFFF, 16'd0, 1'b0, '0);
		repeat (3) add_step(7'd5, 7'd5, 8'h00, 16'hFFFF, 16'd0, 1'b0, '0);
		// improvement while circling clears the counter first
		add_step(7'd5, 7'd0, 8'h04, 16'hFFFF, 16'd0, 1'b0, '0);
		// circling ends on timeout
		repeat (5) add_step(7'd5, 7'd0, 8'h04, 16'hFFFF, 16'd0, 1'b0, '0);
		// content while circling, self neighbor
		repeat (3) add_step(7'd7, 7'd7, 8'h00, 16'hFFFF, 16'd0, 1'b0, '0);
		add_step(7'd7, 7'd7, 8'hFF, 16'hFFFF, 16'd0, 1'b0, '0);
		repeat (2) add_step(7'd6, 7'd7, 8'h00, 16'hFFFF, 16'd0, 1'b0, '0);
		add_step(7'd8, 7'd6, 8'h00, 16'hFFFF, 16'd0, 1'b0, '0);
	endtask

	// ------------------------------------------------------------------------
	// result checker
	// ------------------------------------------------------------------------
	task automatic report_field(input string field, input int unsigned want,
			input int unsigned got);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		errors++;
	endtask

	decision_t head;

	always @(posedge clk) begin
		if (result_bus.valid && result_bus.ready) begin
			if (pending_decisions.size() == 0) begin
				$display("%0t: result with nothing expected, actual motion %0d wait %0d",
					$time, result_bus.motion_kind, result_bus.wait_count);
				errors++;
			end else begin
				head = pending_decisions.pop_front();
				results_checked++;
				if (result_bus.motion_kind !== head.motion)
					report_field("motion_kind", head.motion, result_bus.motion_kind);
				if (result_bus.content !== head.content)
					report_field("content", head.content, result_bus.content);
				if (result_bus.match_score !== head.score)
					report_field("match_score", head.score, result_bus.match_score);
				if (result_bus.pattern_rank !== head.rank)
					report_field("pattern_rank", head.rank, result_bus.pattern_rank);
				if (result_bus.now_circling !== head.circling)
					report_field("now_circling", head.circling, result_bus.now_circling);
				if (result_bus.wait_count !== head.wait_cnt)
					report_field("wait_count", head.wait_cnt, result_bus.wait_count);
			end
		end
	end

	// ------------------------------------------------------------------------
	// result sink stalls, pattern changes every window
	// ------------------------------------------------------------------------
	initial begin
		result_bus.ready <= 1'b0;
		stall_window = 0;
		stall_phase = 0;
		forever begin
			@(posedge clk);
			if (stall_window == 0) begin
				stall_mode   = $urandom_range(0, 3);
				stall_window = $urandom_range(32, 160);
				stall_period = $urandom_range(2, 6);
			end
			stall_window--;
			stall_phase++;
			case (stall_mode)
				0: result_bus.ready <= 1'b1;
				1: result_bus.ready <= $urandom_range(0, 1);
				2: result_bus.ready <= (stall_phase % stall_period) != 0;
				default: result_bus.ready <= stall_phase[3];
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// watchdog on cycles without any handshake or write
	// ------------------------------------------------------------------------
	int idle_cycles;

	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((step_bus.valid && step_bus.ready) || (result_bus.valid && result_bus.ready)
					|| cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no progress for %0d cycles, %0d items outstanding",
			$time, IDLE_LIMIT, pending_decisions.size());
		$display("end of test: mismatches");
		$finish;
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	directed_row_t row;
	link_counts_t  cnt;
	logic [lpmc_pkg::ID_W-1:0] aid;
	logic [lpmc_pkg::ID_W-1:0] nid;
	logic [lpmc_pkg::LINKS-1:0] mask;
	int pool_base;
	int pool_size;
	int roll;

	initial begin
		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_index             <= lpmc_pkg::REG_LINK_THRESHOLD;
		cfg_data              <= '0;
		step_bus.valid        <= 1'b0;
		step_bus.agent_id     <= '0;
		step_bus.neighbor_id  <= '0;
		step_bus.link_count_0 <= '0;
		step_bus.link_count_1 <= '0;
		step_bus.link_count_2 <= '0;
		step_bus.link_count_3 <= '0;
		step_bus.link_count_4 <= '0;
		step_bus.link_count_5 <= '0;
		step_bus.link_count_6 <= '0;
		step_bus.link_count_7 <= '0;

		link_threshold_q = lpmc_pkg::LINK_THRESHOLD_RST;
		improve_wait_q   = lpmc_pkg::IMPROVE_WAIT_RST;
		circle_timeout_q = lpmc_pkg::CIRCLE_TIMEOUT_RST;
		wait_scale_q     = lpmc_pkg::WAIT_SCALE_RST;
		for (int a = 0; a < AGENTS; a++) begin
			agent_mem[a] = '0;
			home_mask[a] = $urandom;
		end
		errors = 0;
		steps_sent = 0;
		results_checked = 0;
		settings_applied = 0;
		content_seen = 0;
		circling_seen = 0;
		attract_seen = 0;
		saturated_seen = 0;
		burst_left = 0;
		build_directed();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (directed_rows[r]) begin
			row = directed_rows[r];
			if (row.kind == ROW_SETTINGS) begin
				apply_settings(row.regs[0], row.regs[1], row.regs[2], row.regs[3]);
			end else begin
				for (int j = 0; j < lpmc_pkg::LINKS; j++)
					cnt[j] = row.mask[j] ? row.hi : row.lo;
				send_step(row.agent, row.nb, cnt, row.typed, row.want);
			end
		end

		// random phases, each under its own register setting
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: apply_settings(16'd50, 16'd200, 16'd1000, 16'd200);
				1: apply_settings(16'd0, 16'd0, 16'd0, 16'd0);
				2: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				3: apply_settings(16'd1000, 16'd3, 16'd8, 16'd1);
				4: apply_settings(16'd30000, 16'd10, 16'd40, 16'd5);
				5: apply_settings($urandom, $urandom_range(0, 20), $urandom_range(0, 60),
					$urandom_range(0, 10));
				default: apply_settings(16'd12, 16'd1, 16'd2, 16'd0);
			endcase
			pool_base = $urandom_range(0, 127);
			pool_size = (ph == 3) ? AGENTS : $urandom_range(1, 6);

			for (int n = 0; n < PHASE_STEPS; n++) begin
				aid = (pool_base + $urandom_range(0, pool_size - 1)) % AGENTS;
				roll = $urandom_range(0, 9);
				if (roll < 6)
					nid = (pool_base + $urandom_range(0, pool_size - 1)) % AGENTS;
				else if (roll < 8)
					nid = aid;
				else
					nid = $urandom_range(0, 127);

				// mostly the agent's own pattern or a variant of it, sometimes a template
				roll = $urandom_range(0, 99);
				if (roll < 50)
					mask = home_mask[aid];
				else if (roll < 65)
					mask = lpmc_pkg::TMPL_BITS[$urandom_range(0, lpmc_pkg::NUM_TEMPLATES - 1)];
				else if (roll < 75)
					mask = home_mask[aid] ^ (8'h01 << $urandom_range(0, 7));
				else
					mask = home_mask[aid] | (8'h11 << $urandom_range(0, 3));
				if ($urandom_range(0, 19) == 0)
					home_mask[aid] = $urandom;

				// noise: raw counts with no pattern behind them
				if ($urandom_range(0, 6) == 0) begin
					for (int j = 0; j < lpmc_pkg::LINKS; j++)
						cnt[j] = $urandom;
				end else begin
					cnt = counts_for(mask);
				end
				send_step(aid, nid, cnt, 1'b0, '0);
			end
		end

		drain_pending();
		repeat (8) @(posedge clk);

		$display("covered %0d steps and %0d checked results over %0d register settings",
			steps_sent, results_checked, settings_applied);
		$display("content %0d, circling %0d, attraction %0d, saturated counter %0d",
			content_seen, circling_seen, attract_seen, saturated_seen);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- files.f -----
design/lpmc_pkg.sv
design/lpmc_step_if.sv
design/lpmc_result_if.sv
design/lpmc_ram.sv
design/lpmc_score.sv
design/lattice_pattern_mode_controller_top.sv
dv/tb_top.sv
